// ===== design/hcirgb_pkg.sv =====
// Shared types, constants and the quarter-wave cosine table for the HCI to RGB converter.
`timescale 1ns / 1ps

package hcirgb_pkg;

   localparam int HUE_FRAC_BITS   = 7;
   localparam int VALUE_FRAC_BITS = 12;
   localparam int COS_N           = 1024;
   localparam int COS_FRAC_BITS   = 16;

   localparam int HUE_W   = 16;
   localparam int VALUE_W = 13;
   localparam int CHAN_W  = 15;
   localparam int COS_W   = COS_FRAC_BITS + 1;
   localparam int ADDR_W  = $clog2(COS_N + 1);
   localparam int POS_W   = 14;

   localparam int FULL_TURN   = 360 << HUE_FRAC_BITS;
   localparam int QUARTER     = 90 << HUE_FRAC_BITS;
   localparam int PHASE_RED   = 0;
   localparam int PHASE_GREEN = (FULL_TURN / 3) * 2;
   localparam int PHASE_BLUE  = FULL_TURN / 3;
   localparam int VALUE_ONE   = 1 << VALUE_FRAC_BITS;

   // idx = (pos * COS_N + QUARTER / 2) / QUARTER reduced to (8 * pos + 45) / 90
   localparam int IDX_SHIFT = 3;
   localparam int IDX_ADD   = 45;
   localparam int NUM_W     = POS_W + IDX_SHIFT;
   localparam int RECIP90_SHIFT = 24;
   localparam int RECIP90   = (1 << RECIP90_SHIFT) / 90 + 1;
   localparam int IDXP_W    = NUM_W + 18;

   // m = (2 * c * mag + 3 * 2^15) / (3 * 2^16) = ((c * mag + 3 * 2^14) >> 15) / 3
   localparam int CM_W      = VALUE_W + COS_W;
   localparam int CM_ROUND  = 3 << (COS_FRAC_BITS - 2);
   localparam int T_SHIFT   = COS_FRAC_BITS - 1;
   localparam int T_W       = CM_W - T_SHIFT;
   localparam int RECIP3_SHIFT = 16;
   localparam int RECIP3    = (1 << RECIP3_SHIFT) / 3 + 1;
   localparam int MAG_W     = 13;

   localparam int NUM_STAGES = 8;
   localparam int ST_ANGLE   = 2;
   localparam int ST_QUAD    = 3;
   localparam int ST_INDEX   = 4;
   localparam int ST_READ    = 5;
   localparam int ST_PROD    = 6;
   localparam int ST_SCALE   = 7;
   localparam int ST_OUT     = 8;

   typedef logic [NUM_STAGES:1] stage_en_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [COS_W-1:0]  data;
   } fill_type;

   typedef logic [COS_W-1:0] cos_tab_type [0:COS_N];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      for (int k = 0; k <= COS_N; k++) begin
         x    = (HALF_PI_Q30 * 64'(k) + 64'(COS_N / 2)) / 64'(COS_N);
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = longint'(term);
         for (int n = 1; n <= 12; n++) begin
            if (term != 64'd0) begin
               term = (term * x2) >> 30;
               term = term / 64'((2 * n - 1) * (2 * n));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (64'(sum) + (64'd1 << 13)) >> 14;
         if (v > (64'd1 << COS_FRAC_BITS)) begin
            v = 64'd1 << COS_FRAC_BITS;
         end
         tab[k] = v[COS_W-1:0];
      end
      return tab;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

endpackage

// ===== design/hcirgb_req_if.sv =====
// Pixel input channel: valid/ready handshake with hue, chroma and intensity.
`timescale 1ns / 1ps

interface hcirgb_req_if;
   logic                               valid;
   logic                               ready;
   logic [hcirgb_pkg::HUE_W-1:0]       hue;
   logic [hcirgb_pkg::VALUE_W-1:0]     chroma;
   logic [hcirgb_pkg::VALUE_W-1:0]     intensity;

   modport source (output valid, output hue, output chroma, output intensity, input ready);
   modport sink   (input valid, input hue, input chroma, input intensity, output ready);
endinterface

// ===== design/hcirgb_rsp_if.sv =====
// Pixel result channel: valid/ready handshake with red, green, blue and range warning.
`timescale 1ns / 1ps

interface hcirgb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hcirgb_pkg::CHAN_W-1:0] red;
   logic signed [hcirgb_pkg::CHAN_W-1:0] green;
   logic signed [hcirgb_pkg::CHAN_W-1:0] blue;
   logic                                range_warning;

   modport source (output valid, output red, output green, output blue,
                   output range_warning, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input range_warning, output ready);
endinterface

// ===== design/hci_to_rgb_converter.sv =====
// HCI to RGB pixel converter. Each accepted word carries hue (1/128 degree units,
// reduced modulo 360 degrees), chroma and intensity (unsigned Q1.12); each result word
// carries red, green and blue as signed Q.12 values, intensity plus two thirds of chroma
// times the cosine of the hue offset by 0, 120 or 240 degrees, rounded to nearest and not
// clamped, plus a warning set when hue exceeds 360 degrees or chroma or intensity
// exceeds 1.0. The datapath is an 8-stage pipeline that takes one word per clock when
// the output is not stalled. A stalled output holds the pipeline stage by stage, so
// bubbles still fill behind it. Each channel reads its own copy of the 1025-entry
// quarter-wave cosine RAM. After reset the RAMs are loaded by a sweep over all 1025
// entries, during which req_bus.ready stays low.
`timescale 1ns / 1ps

module hci_to_rgb_converter (
   input  logic                clock,
   input  logic                reset,
   hcirgb_req_if.sink          req_bus,
   hcirgb_rsp_if.source        rsp_bus
);

   localparam int NS = hcirgb_pkg::NUM_STAGES;

   hcirgb_pkg::stage_en_type en;
   logic [NS:1]              valid_ff, valid_in;
   logic                     accept;
   logic                     fill_done;
   hcirgb_pkg::fill_type     fill;

   logic [hcirgb_pkg::HUE_W-1:0]   hue_ff, hue_in;
   logic [hcirgb_pkg::VALUE_W-1:0] chroma_ff [1:hcirgb_pkg::ST_READ];
   logic [hcirgb_pkg::VALUE_W-1:0] intensity_ff [1:hcirgb_pkg::ST_SCALE];
   logic                           warn_ff [1:NS];
   logic                           warn_in;

   logic signed [hcirgb_pkg::CHAN_W-1:0] red, green, blue;

   hcirgb_fill u_fill (
      .clock (clock),
      .reset (reset),
      .fill  (fill),
      .done  (fill_done)
   );

   always_comb begin
      en[NS] = !valid_ff[NS] || rsp_bus.ready;
      for (int k = NS - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_bus.ready = en[1] && fill_done;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in[1] = accept;
      for (int k = 2; k <= NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_comb begin
      if (req_bus.hue >= hcirgb_pkg::HUE_W'(hcirgb_pkg::FULL_TURN)) begin
         hue_in = req_bus.hue - hcirgb_pkg::HUE_W'(hcirgb_pkg::FULL_TURN);
      end else begin
         hue_in = req_bus.hue;
      end
      warn_in = (req_bus.hue > hcirgb_pkg::HUE_W'(hcirgb_pkg::FULL_TURN))
             || (req_bus.chroma > hcirgb_pkg::VALUE_W'(hcirgb_pkg::VALUE_ONE))
             || (req_bus.intensity > hcirgb_pkg::VALUE_W'(hcirgb_pkg::VALUE_ONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hue_ff          <= hue_in;
         chroma_ff[1]    <= req_bus.chroma;
         intensity_ff[1] <= req_bus.intensity;
         warn_ff[1]      <= warn_in;
      end
      for (int k = 2; k <= hcirgb_pkg::ST_READ; k++) begin
         if (en[k]) begin
            chroma_ff[k] <= chroma_ff[k-1];
         end
      end
      for (int k = 2; k <= hcirgb_pkg::ST_SCALE; k++) begin
         if (en[k]) begin
            intensity_ff[k] <= intensity_ff[k-1];
         end
      end
      for (int k = 2; k <= NS; k++) begin
         if (en[k]) begin
            warn_ff[k] <= warn_ff[k-1];
         end
      end
   end

   hcirgb_lane u_red (
      .clock        (clock),
      .en           (en),
      .fill         (fill),
      .phase        (hcirgb_pkg::HUE_W'(hcirgb_pkg::PHASE_RED)),
      .hue_s1       (hue_ff),
      .chroma_s5    (chroma_ff[hcirgb_pkg::ST_READ]),
      .intensity_s7 (intensity_ff[hcirgb_pkg::ST_SCALE]),
      .chan         (red)
   );

   hcirgb_lane u_green (
      .clock        (clock),
      .en           (en),
      .fill         (fill),
      .phase        (hcirgb_pkg::HUE_W'(hcirgb_pkg::PHASE_GREEN)),
      .hue_s1       (hue_ff),
      .chroma_s5    (chroma_ff[hcirgb_pkg::ST_READ]),
      .intensity_s7 (intensity_ff[hcirgb_pkg::ST_SCALE]),
      .chan         (green)
   );

   hcirgb_lane u_blue (
      .clock        (clock),
      .en           (en),
      .fill         (fill),
      .phase        (hcirgb_pkg::HUE_W'(hcirgb_pkg::PHASE_BLUE)),
      .hue_s1       (hue_ff),
      .chroma_s5    (chroma_ff[hcirgb_pkg::ST_READ]),
      .intensity_s7 (intensity_ff[hcirgb_pkg::ST_SCALE]),
      .chan         (blue)
   );

   assign rsp_bus.valid         = valid_ff[NS];
   assign rsp_bus.red           = red;
   assign rsp_bus.green         = green;
   assign rsp_bus.blue          = blue;
   assign rsp_bus.range_warning = warn_ff[NS];

endmodule

// ===== design/hcirgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hcirgb_ram #(
   parameter int WIDTH = hcirgb_pkg::COS_W,
   parameter int DEPTH = hcirgb_pkg::COS_N + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hcirgb_fill.sv =====
// Post-reset sweep that loads the cosine table into the lane RAMs.
`timescale 1ns / 1ps

module hcirgb_fill (
   input  logic                 clock,
   input  logic                 reset,
   output hcirgb_pkg::fill_type fill,
   output logic                 done
);

   logic [hcirgb_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          wr_en_ff;
   logic [hcirgb_pkg::ADDR_W-1:0] addr_ff;
   logic [hcirgb_pkg::COS_W-1:0]  data_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (cnt_ff == hcirgb_pkg::ADDR_W'(hcirgb_pkg::COS_N)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         busy_ff  <= 1'b1;
         wr_en_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         wr_en_ff <= busy_ff;
      end
      addr_ff <= cnt_ff;
      data_ff <= hcirgb_pkg::COS_TAB[cnt_ff];
   end

   assign fill.wr_en = wr_en_ff;
   assign fill.addr  = addr_ff;
   assign fill.data  = data_ff;
   assign done       = !busy_ff && !wr_en_ff;

endmodule

// ===== design/hcirgb_lane.sv =====
// One color channel: phase offset, quadrant split, table lookup, chroma scaling and sum.
`timescale 1ns / 1ps

module hcirgb_lane (
   input  logic                                  clock,
   input  hcirgb_pkg::stage_en_type              en,
   input  hcirgb_pkg::fill_type                  fill,
   input  logic [hcirgb_pkg::HUE_W-1:0]          phase,
   input  logic [hcirgb_pkg::HUE_W-1:0]          hue_s1,
   input  logic [hcirgb_pkg::VALUE_W-1:0]        chroma_s5,
   input  logic [hcirgb_pkg::VALUE_W-1:0]        intensity_s7,
   output logic signed [hcirgb_pkg::CHAN_W-1:0]  chan
);

   localparam int HW = hcirgb_pkg::HUE_W;

   logic [HW-1:0]                    angle_ff, angle_in;
   logic [HW:0]                      angle_sum;
   logic [1:0]                       quad_ff, quad_in;
   logic [hcirgb_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [HW-1:0]                    pos_full;
   logic [hcirgb_pkg::NUM_W-1:0]     num;
   logic [hcirgb_pkg::IDXP_W-1:0]    idx_prod;
   logic [hcirgb_pkg::ADDR_W-1:0]    idx;
   logic [hcirgb_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic                             neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [hcirgb_pkg::COS_W-1:0]     mag;
   logic [hcirgb_pkg::CM_W-1:0]      cm_ff, cm_in;
   logic [hcirgb_pkg::CM_W-1:0]      cm_round;
   logic [hcirgb_pkg::T_W-1:0]       tq;
   logic [2*hcirgb_pkg::T_W-1:0]     m_prod;
   logic [hcirgb_pkg::MAG_W-1:0]     m_ff, m_in;
   logic [hcirgb_pkg::CHAN_W-1:0]    chan_ff, chan_in;

   always_comb begin
      angle_sum = {1'b0, hue_s1} + {1'b0, phase};
      if (angle_sum >= (HW+1)'(hcirgb_pkg::FULL_TURN)) begin
         angle_in = HW'(angle_sum - (HW+1)'(hcirgb_pkg::FULL_TURN));
      end else begin
         angle_in = angle_sum[HW-1:0];
      end
   end

   always_comb begin
      if (angle_ff >= HW'(3 * hcirgb_pkg::QUARTER)) begin
         quad_in  = 2'd3;
         pos_full = angle_ff - HW'(3 * hcirgb_pkg::QUARTER);
      end else if (angle_ff >= HW'(2 * hcirgb_pkg::QUARTER)) begin
         quad_in  = 2'd2;
         pos_full = angle_ff - HW'(2 * hcirgb_pkg::QUARTER);
      end else if (angle_ff >= HW'(hcirgb_pkg::QUARTER)) begin
         quad_in  = 2'd1;
         pos_full = angle_ff - HW'(hcirgb_pkg::QUARTER);
      end else begin
         quad_in  = 2'd0;
         pos_full = angle_ff;
      end
      pos_in = pos_full[hcirgb_pkg::POS_W-1:0];
   end

   always_comb begin
      num      = {pos_ff, {hcirgb_pkg::IDX_SHIFT{1'b0}}} + hcirgb_pkg::NUM_W'(hcirgb_pkg::IDX_ADD);
      idx_prod = hcirgb_pkg::IDXP_W'(num) * hcirgb_pkg::IDXP_W'(hcirgb_pkg::RECIP90);
      idx      = idx_prod[hcirgb_pkg::RECIP90_SHIFT +: hcirgb_pkg::ADDR_W];
      if (quad_ff[0]) begin
         addr_in = hcirgb_pkg::ADDR_W'(hcirgb_pkg::COS_N) - idx;
      end else begin
         addr_in = idx;
      end
   end

   hcirgb_ram #(
      .WIDTH (hcirgb_pkg::COS_W),
      .DEPTH (hcirgb_pkg::COS_N + 1)
   ) u_cos_ram (
      .clock   (clock),
      .wr_en   (fill.wr_en),
      .wr_addr (fill.addr),
      .wr_data (fill.data),
      .rd_en   (en[hcirgb_pkg::ST_READ]),
      .rd_addr (addr_ff),
      .rd_data (mag)
   );

   assign cm_in = hcirgb_pkg::CM_W'(chroma_s5) * hcirgb_pkg::CM_W'(mag);

   always_comb begin
      cm_round = cm_ff + hcirgb_pkg::CM_W'(hcirgb_pkg::CM_ROUND);
      tq       = cm_round[hcirgb_pkg::T_SHIFT +: hcirgb_pkg::T_W];
      m_prod   = (2*hcirgb_pkg::T_W)'(tq) * (2*hcirgb_pkg::T_W)'(hcirgb_pkg::RECIP3);
      m_in     = m_prod[hcirgb_pkg::RECIP3_SHIFT +: hcirgb_pkg::MAG_W];
   end

   always_comb begin
      if (neg7_ff) begin
         chan_in = hcirgb_pkg::CHAN_W'(intensity_s7) - hcirgb_pkg::CHAN_W'(m_ff);
      end else begin
         chan_in = hcirgb_pkg::CHAN_W'(intensity_s7) + hcirgb_pkg::CHAN_W'(m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[hcirgb_pkg::ST_ANGLE]) begin
         angle_ff <= angle_in;
      end
      if (en[hcirgb_pkg::ST_QUAD]) begin
         quad_ff <= quad_in;
         pos_ff  <= pos_in;
      end
      if (en[hcirgb_pkg::ST_INDEX]) begin
         addr_ff <= addr_in;
         neg4_ff <= quad_ff[1] ^ quad_ff[0];
      end
      if (en[hcirgb_pkg::ST_READ]) begin
         neg5_ff <= neg4_ff;
      end
      if (en[hcirgb_pkg::ST_PROD]) begin
         cm_ff   <= cm_in;
         neg6_ff <= neg5_ff;
      end
      if (en[hcirgb_pkg::ST_SCALE]) begin
         m_ff    <= m_in;
         neg7_ff <= neg6_ff;
      end
      if (en[hcirgb_pkg::ST_OUT]) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = signed'(chan_ff);

endmodule
